@@ rtl/core/abdcf_pkg.sv @@
package abdcf_pkg;

	localparam int GRID_MAX = 256;
	localparam int CFG_IDX_W = 3;
	localparam logic signed [13:0] LOG2E_Q12 = 14'sd5909;

	localparam logic [CFG_IDX_W-1:0] REG_HSTRIDE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WSTRIDE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMG_H   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IMG_W   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SZ  = 3'd4;

	typedef struct packed {
		logic signed [15:0] anchor_left;
		logic signed [15:0] anchor_top;
		logic signed [15:0] anchor_right;
		logic signed [15:0] anchor_bottom;
		logic [7:0]         grid_row;
		logic [7:0]         grid_col;
		logic signed [15:0] delta_cx;
		logic signed [15:0] delta_cy;
		logic signed [15:0] delta_logw;
		logic signed [15:0] delta_logh;
	} req_t;

	typedef struct packed {
		logic [15:0] box_left;
		logic [15:0] box_top;
		logic [15:0] box_right;
		logic [15:0] box_bottom;
		logic        keep;
	} rsp_t;

	function automatic logic [17:0] pow2_tab(input logic [4:0] k);
		logic [17:0] v;
		case (k)
			5'd0: v = 18'd65536;
			5'd1: v = 18'd68438;
			5'd2: v = 18'd71468;
			5'd3: v = 18'd74632;
			5'd4: v = 18'd77936;
			5'd5: v = 18'd81386;
			5'd6: v = 18'd84990;
			5'd7: v = 18'd88752;
			5'd8: v = 18'd92682;
			5'd9: v = 18'd96785;
			5'd10: v = 18'd101070;
			5'd11: v = 18'd105545;
			5'd12: v = 18'd110218;
			5'd13: v = 18'd115098;
			5'd14: v = 18'd120194;
			5'd15: v = 18'd125515;
			default: v = 18'd131072;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/core/abdcf_axis.sv @@
module abdcf_axis (
	input  logic               clk,
	input  logic [5:0]         adv,
	input  logic signed [24:0] lo,
	input  logic signed [24:0] hi,
	input  logic signed [15:0] d,
	input  logic signed [15:0] dlog,
	input  logic [15:0]        lim,
	output logic [15:0]        out_lo,
	output logic [15:0]        out_hi
);

	logic signed [17:0] size_s2;
	logic signed [25:0] sum_s2;
	logic signed [15:0] d_s2;
	logic signed [28:0] t_s2;
	logic signed [17:0] size_s3;
	logic signed [25:0] sum_s3;
	logic signed [33:0] dsz_s3;
	logic [4:0]         sh_s3;
	logic [3:0]         ti_s3;
	logic [19:0]        r_s3;
	logic signed [17:0] size_s4;
	logic signed [25:0] sum_s4;
	logic signed [33:0] dsz_s4;
	logic [4:0]         sh_s4;
	logic [17:0]        m_s4;
	logic signed [36:0] sm_s5;
	logic [4:0]         sh_s5;
	logic signed [63:0] ctr_s5;
	logic signed [63:0] ctr_s6;
	logic signed [63:0] nsz_s6;
	logic [15:0]        lo_s7;
	logic [15:0]        hi_s7;

	logic signed [28:0] u;
	logic [17:0]        ta;
	logic [17:0]        tb;
	logic [32:0]        ip;

	function automatic logic [15:0] clip(input logic signed [63:0] v, input logic [15:0] l);
		logic signed [63:0] q;
		if (v <= 64'sd0) begin
			return 16'd0;
		end
		q = (v + (64'sd1 <<< 28)) >>> 29;
		if (q > $signed({48'd0, l})) begin
			return l;
		end
		return q[15:0];
	endfunction

	assign u  = t_s2 + (29'sd12 <<< 24);
	assign ta = abdcf_pkg::pow2_tab({1'b0, ti_s3});
	assign tb = abdcf_pkg::pow2_tab({1'b0, ti_s3} + 5'd1);
	assign ip = (33'(tb) - 33'(ta)) * 33'(r_s3);

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			size_s2 <= 18'(hi - lo);
			sum_s2  <= 26'(hi) + 26'(lo);
			d_s2    <= d;
			t_s2    <= 29'(dlog) * 29'(abdcf_pkg::LOG2E_Q12);
		end
		if (adv[1]) begin
			size_s3 <= size_s2;
			sum_s3  <= sum_s2;
			dsz_s3  <= 34'(d_s2) * 34'(size_s2);
			sh_s3   <= u[28:24];
			ti_s3   <= u[23:20];
			r_s3    <= u[19:0];
		end
		if (adv[2]) begin
			size_s4 <= size_s3;
			sum_s4  <= sum_s3;
			dsz_s4  <= dsz_s3;
			sh_s4   <= sh_s3;
			m_s4    <= ta + 18'(ip >> 20);
		end
		if (adv[3]) begin
			sm_s5  <= 37'(size_s4) * $signed({19'd0, m_s4});
			sh_s5  <= sh_s4;
			ctr_s5 <= (64'(sum_s4) <<< 28) + (64'(dsz_s4) <<< 17);
		end
		if (adv[4]) begin
			ctr_s6 <= ctr_s5;
			nsz_s6 <= 64'(sm_s5) <<< sh_s5;
		end
		if (adv[5]) begin
			lo_s7 <= clip(ctr_s6 - nsz_s6, lim);
			hi_s7 <= clip(ctr_s6 + nsz_s6, lim);
		end
	end

	assign out_lo = lo_s7;
	assign out_hi = hi_s7;

endmodule

@@ rtl/core/anchor_box_decode_clip_filter.sv @@
// Channel  | Direction | Handshake          | Payload
// request  | in        | start / busy       | req (abdcf_pkg::req_t)
// result   | out       | done strobe        | rsp (abdcf_pkg::rsp_t)
// config   | in        | cfg_valid/ready    | cfg_index, cfg_data
// One request per cycle; the done strobe is taken from the end of the valid shift register.
// Pipeline: grid multiply, size/centre, offset multiply, exp table, scale multiply, shift, clip, keep.
// busy is held low: the receiver cannot stall, so the pipeline never holds.
// arst_n clears valid bits and loads register reset values.
module anchor_box_decode_clip_filter #(
	parameter int GRID_MAX = abdcf_pkg::GRID_MAX
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  abdcf_pkg::req_t                   req,
	output logic                              done,
	output abdcf_pkg::rsp_t                   rsp,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [abdcf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [15:0]                       cfg_data
);

	localparam logic [7:0] GSAT = (GRID_MAX - 1 > 255) ? 8'd255 : 8'(GRID_MAX - 1);

	logic [15:0] hstride_q, wstride_q, imgh_q, imgw_q, minsz_q;
	logic [7:0]  vld;
	logic [5:0]  adv;
	logic [7:0]  gr, gc;

	logic [23:0]        wsh_s1, hsh_s1;
	abdcf_pkg::req_t    req_s1;
	logic [15:0]        bx1, bx2, by1, by2;
	abdcf_pkg::rsp_t    rsp_s8;
	logic signed [24:0] x1w, x2w, y1w, y2w;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign adv       = 6'h3f;

	assign gr = (req.grid_row > GSAT) ? GSAT : req.grid_row;
	assign gc = (req.grid_col > GSAT) ? GSAT : req.grid_col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hstride_q <= 16'd256;
			wstride_q <= 16'd256;
			imgh_q    <= 16'hffff;
			imgw_q    <= 16'hffff;
			minsz_q   <= 16'd0;
			vld       <= '0;
		end else begin
			vld <= {vld[6:0], start & ~busy};
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					abdcf_pkg::REG_HSTRIDE: hstride_q <= cfg_data;
					abdcf_pkg::REG_WSTRIDE: wstride_q <= cfg_data;
					abdcf_pkg::REG_IMG_H:   imgh_q    <= cfg_data;
					abdcf_pkg::REG_IMG_W:   imgw_q    <= cfg_data;
					abdcf_pkg::REG_MIN_SZ:  minsz_q   <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		wsh_s1 <= gc * wstride_q;
		hsh_s1 <= gr * hstride_q;
		req_s1 <= req;
	end

	// shift corners; 25 bits hold the widest grid offset
	assign x1w = 25'(req_s1.anchor_left)   + $signed({1'b0, wsh_s1});
	assign x2w = 25'(req_s1.anchor_right)  + $signed({1'b0, wsh_s1});
	assign y1w = 25'(req_s1.anchor_top)    + $signed({1'b0, hsh_s1});
	assign y2w = 25'(req_s1.anchor_bottom) + $signed({1'b0, hsh_s1});

	abdcf_axis u_x (.clk, .adv, .lo(x1w), .hi(x2w), .d(req_s1.delta_cx),
		.dlog(req_s1.delta_logw), .lim(imgw_q), .out_lo(bx1), .out_hi(bx2));
	abdcf_axis u_y (.clk, .adv, .lo(y1w), .hi(y2w), .d(req_s1.delta_cy),
		.dlog(req_s1.delta_logh), .lim(imgh_q), .out_lo(by1), .out_hi(by2));

	always_ff @(posedge clk) begin
		rsp_s8.box_left   <= bx1;
		rsp_s8.box_right  <= bx2;
		rsp_s8.box_top    <= by1;
		rsp_s8.box_bottom <= by2;
		rsp_s8.keep <= ($signed(18'(bx2) - 18'(bx1)) > $signed({2'b0, minsz_q}))
			&& ($signed(18'(by2) - 18'(by1)) > $signed({2'b0, minsz_q}))
			&& ({1'b0, bx1} + {1'b0, bx2} < {imgw_q, 1'b0})
			&& ({1'b0, by1} + {1'b0, by2} < {imgh_q, 1'b0});
	end

	assign done = vld[7];
	assign rsp  = rsp_s8;

endmodule

@@ tb/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 8;
	localparam longint MAX_CYCLES = 400000;
	localparam int REQ_W = $bits(abdcf_pkg::req_t);

	class box_scoreboard;
		abdcf_pkg::rsp_t pending[$];
		int errors;
		int checked;
		int kept;
		logic [15:0] hstride, wstride, img_h, img_w, min_sz;

		function void set_reg(logic [abdcf_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
			case (idx)
				abdcf_pkg::REG_HSTRIDE: hstride = val;
				abdcf_pkg::REG_WSTRIDE: wstride = val;
				abdcf_pkg::REG_IMG_H:   img_h = val;
				abdcf_pkg::REG_IMG_W:   img_w = val;
				abdcf_pkg::REG_MIN_SZ:  min_sz = val;
				default: ;
			endcase
		endfunction

		function longint exp_scale(longint sz, longint dlog);
			longint t, u, s, f, i, r, m;
			longint tab[17];
			tab = '{65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752, 92682,
				96785, 101070, 105545, 110218, 115098, 120194, 125515, 131072};
			t = dlog * 5909;
			u = t + (longint'(12) << 24);
			s = (u >> 24) & 31;
			f = u & 64'hFFFFFF;
			i = (f >> 20) & 15;
			r = f & 64'hFFFFF;
			m = tab[i] + (((tab[i+1] - tab[i]) * r) >>> 20);
			return sz * m * (longint'(1) << s);
		endfunction

		function longint clip_corner(longint v, longint lim);
			longint q;
			if (v <= 0) return 0;
			q = (v + (longint'(1) << 28)) >>> 29;
			return (q > lim) ? lim : q;
		endfunction

		function void decode_axis(longint lo, longint hi, longint d, longint dlog,
			longint lim, output longint olo, output longint ohi);
			longint sz, ctr, nsz;
			sz = hi - lo;
			ctr = (lo + hi) * (longint'(1) << 28) + d * sz * (longint'(1) << 17);
			nsz = exp_scale(sz, dlog);
			olo = clip_corner(ctr - nsz, lim);
			ohi = clip_corner(ctr + nsz, lim);
		endfunction

		function void note_request(abdcf_pkg::req_t r);
			longint ws, hs, bx1, by1, bx2, by2;
			abdcf_pkg::rsp_t e;
			ws = longint'(r.grid_col) * longint'(wstride);
			hs = longint'(r.grid_row) * longint'(hstride);
			decode_axis(longint'(r.anchor_left) + ws, longint'(r.anchor_right) + ws,
				longint'(r.delta_cx), longint'(r.delta_logw), longint'(img_w), bx1, bx2);
			decode_axis(longint'(r.anchor_top) + hs, longint'(r.anchor_bottom) + hs,
				longint'(r.delta_cy), longint'(r.delta_logh), longint'(img_h), by1, by2);
			e.box_left = bx1[15:0];
			e.box_top = by1[15:0];
			e.box_right = bx2[15:0];
			e.box_bottom = by2[15:0];
			e.keep = (bx2 - bx1) > longint'(min_sz) && (by2 - by1) > longint'(min_sz) &&
				(bx1 + bx2) < 2 * longint'(img_w) && (by1 + by2) < 2 * longint'(img_h);
			pending.push_back(e);
		endfunction

		function void check_result(abdcf_pkg::rsp_t a);
			abdcf_pkg::rsp_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %p", $time, a);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (a.keep) kept++;
			if (a.box_left !== e.box_left)
				$display("%0t: box_left exp %0d got %0d", $time, e.box_left, a.box_left);
			if (a.box_top !== e.box_top)
				$display("%0t: box_top exp %0d got %0d", $time, e.box_top, a.box_top);
			if (a.box_right !== e.box_right)
				$display("%0t: box_right exp %0d got %0d", $time, e.box_right, a.box_right);
			if (a.box_bottom !== e.box_bottom)
				$display("%0t: box_bottom exp %0d got %0d", $time, e.box_bottom, a.box_bottom);
			if (a.keep !== e.keep)
				$display("%0t: keep exp %0d got %0d", $time, e.keep, a.keep);
			if (a !== e) errors++;
		endfunction
	endclass

	logic clk, arst_n, start, busy, done, cfg_valid, cfg_ready;
	abdcf_pkg::req_t req;
	abdcf_pkg::rsp_t rsp;
	logic [abdcf_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [15:0] cfg_data;
	box_scoreboard sb;
	longint cycles;
	int n_requests;

	anchor_box_decode_clip_filter i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > MAX_CYCLES) begin
			$display("tb_top failed");
			$finish;
		end
		if (arst_n && done) sb.check_result(rsp);
	end

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) n = 0;
		if (n > 0) start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send_request(abdcf_pkg::req_t r);
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_request(r);
		n_requests++;
	endtask

	task automatic write_reg(logic [abdcf_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_dlog();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 65535));
			default: return 16'($signed($urandom_range(0, 8000)) - 4000);
		endcase
	endfunction

	function automatic abdcf_pkg::req_t rand_request(bit wide);
		abdcf_pkg::req_t r;
		logic signed [15:0] x, y;
		if (wide) begin
			r = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
		end else begin
			x = 16'($urandom_range(0, 4000));
			y = 16'($urandom_range(0, 4000));
			r.anchor_left = x;
			r.anchor_top = y;
			r.anchor_right = x + 16'($urandom_range(0, 3000));
			r.anchor_bottom = y + 16'($urandom_range(0, 3000));
			r.grid_row = 8'($urandom_range(0, 63));
			r.grid_col = 8'($urandom_range(0, 63));
			r.delta_cx = 16'($signed($urandom_range(0, 4000)) - 2000);
			r.delta_cy = 16'($signed($urandom_range(0, 4000)) - 2000);
			r.delta_logw = rand_dlog();
			r.delta_logh = rand_dlog();
		end
		return r;
	endfunction

	function automatic logic [15:0] rand_reg_val(logic [abdcf_pkg::CFG_IDX_W-1:0] idx);
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'hFFFF;
			default: begin
				case (idx)
					abdcf_pkg::REG_HSTRIDE, abdcf_pkg::REG_WSTRIDE:
						return 16'($urandom_range(0, 512));
					abdcf_pkg::REG_MIN_SZ: return 16'($urandom_range(0, 400));
					default: return 16'($urandom_range(1000, 65535));
				endcase
			end
		endcase
	endfunction

	initial begin
		abdcf_pkg::req_t r;
		logic signed [15:0] ext[4];
		sb = new();
		sb.hstride = 256;
		sb.wstride = 256;
		sb.img_h = 16'hFFFF;
		sb.img_w = 16'hFFFF;
		sb.min_sz = 0;
		cycles = 0;
		n_requests = 0;
		arst_n = 0;
		start = 0;
		req = '0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		ext = '{16'sh8000, 16'sh7FFF, 16'sd0, -16'sd1};
		for (int k = 0; k < 4; k++) begin
			r = '0;
			r.anchor_left = ext[k];
			r.anchor_top = ext[3 - k];
			r.anchor_right = ext[(k + 1) % 4];
			r.anchor_bottom = ext[(k + 2) % 4];
			r.grid_row = (k < 2) ? 8'hFF : 8'h00;
			r.grid_col = (k % 2) ? 8'hFF : 8'h00;
			r.delta_cx = ext[(k + 3) % 4];
			r.delta_cy = ext[k];
			r.delta_logw = ext[(k + 2) % 4];
			r.delta_logh = ext[(k + 1) % 4];
			send_request(r);
		end
		r = rand_request(0);
		r.anchor_right = r.anchor_left - 16'sd100;
		send_request(r);
		r = rand_request(0);
		r.delta_logw = 16'sh7FFF;
		r.delta_logh = 16'sh8000;
		send_request(r);
		drain();
		write_reg(abdcf_pkg::REG_IMG_W, 16'd0);
		write_reg(abdcf_pkg::REG_IMG_H, 16'd0);
		write_reg(3'd7, 16'h1234);
		for (int k = 0; k < 4; k++) send_request(rand_request(0));
		drain();
		write_reg(abdcf_pkg::REG_IMG_W, 16'd4000);
		write_reg(abdcf_pkg::REG_IMG_H, 16'd4000);
		write_reg(abdcf_pkg::REG_HSTRIDE, 16'hFFFF);
		write_reg(abdcf_pkg::REG_WSTRIDE, 16'd0);
		write_reg(abdcf_pkg::REG_MIN_SZ, 16'd100);
		for (int k = 0; k < 6; k++) send_request(rand_request(k % 3 == 0));
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			for (int k = 0; k < 5; k++)
				if ($urandom_range(0, 1)) write_reg(3'(k), rand_reg_val(3'(k)));
			for (int k = 0; k < 55; k++) begin
				if ($urandom_range(0, 2) != 0) idle_gap();
				send_request(rand_request($urandom_range(0, 4) == 0));
			end
			drain();
		end

		$display("Sent %0d requests over several register settings; %0d results checked, %0d kept.",
			n_requests, sb.checked, sb.kept);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end
endmodule

@@ files.f @@
rtl/core/abdcf_pkg.sv
rtl/core/abdcf_axis.sv
rtl/core/anchor_box_decode_clip_filter.sv
tb/tb_top.sv
